### hw/rtl/steq_pkg.sv
// shared types, codes and constants for the sorted timer event queue
package steq_pkg;

    // default pool depth and fixed limits
    localparam int POOL_SIZE_DEF = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] TICK_NS_RESET = 32'd1000000;

    // operation codes of the func field
    localparam logic [1:0] FUNC_POST   = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_POSTED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // input beat
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] event_time;
        logic [15:0] handler_id;
        logic [31:0] param;
        logic [5:0]  entry_index;
    } req_t;

    // result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_index;
        logic [15:0] expired_handler;
        logic [31:0] expired_param;
        logic        last;
    } rsp_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_WALK,
        S_FIN,
        S_TICK
    } state_t;

    // read address source for the entry memories
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_FREE,
        RD_LINK
    } rd_sel_t;

    // link table update operations
    typedef enum logic [2:0] {
        LW_NONE,
        LW_POST_PREV,
        LW_POST_SELF,
        LW_DEL_PREV,
        LW_DEL_FREE,
        LW_TICK
    } link_op_t;

    // result beat sources
    typedef enum logic [2:0] {
        EM_NONE,
        EM_FULL,
        EM_POSTED,
        EM_DELETED,
        EM_NOT_FOUND,
        EM_NO_EXPIRY,
        EM_HOLD,
        EM_HOLD_LAST
    } emit_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load_item;
        rd_sel_t  rd_sel;
        logic     pop_free;
        logic     walk_init;
        logic     walk_step;
        logic     now_adv;
        logic     tick_init;
        link_op_t link_op;
        emit_t    emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       free_empty;
        logic       walk_cont;
        logic       found;
        logic       expire;
        logic       any_expired;
    } stat_t;

endpackage

### hw/rtl/steq_ctrl.sv
// controller state machine of the sorted timer event queue
module steq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  steq_pkg::stat_t stat,
    output steq_pkg::cmd_t  cmd,
    output logic            busy
);

    steq_pkg::state_t state_reg;
    steq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= steq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != steq_pkg::S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_sel    = steq_pkg::RD_HEAD;
        cmd.link_op   = steq_pkg::LW_NONE;
        cmd.emit      = steq_pkg::EM_NONE;
        unique case (state_reg)
            steq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = steq_pkg::S_START;
                end
            end
            steq_pkg::S_START:
            begin
                if (stat.func == steq_pkg::FUNC_POST)
                begin
                    if (stat.free_empty)
                    begin
                        cmd.emit   = steq_pkg::EM_FULL;
                        state_next = steq_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_sel = steq_pkg::RD_FREE;
                        state_next = steq_pkg::S_POP;
                    end
                end
                else if (stat.func == steq_pkg::FUNC_DELETE)
                begin
                    cmd.rd_sel    = steq_pkg::RD_HEAD;
                    cmd.walk_init = 1'b1;
                    state_next    = steq_pkg::S_WALK;
                end
                else if (stat.func == steq_pkg::FUNC_TICK)
                begin
                    cmd.rd_sel    = steq_pkg::RD_HEAD;
                    cmd.now_adv   = 1'b1;
                    cmd.tick_init = 1'b1;
                    state_next    = steq_pkg::S_TICK;
                end
                else
                begin
                    state_next = steq_pkg::S_IDLE;
                end
            end
            steq_pkg::S_POP:
            begin
                cmd.pop_free  = 1'b1;
                cmd.rd_sel    = steq_pkg::RD_HEAD;
                cmd.walk_init = 1'b1;
                state_next    = steq_pkg::S_WALK;
            end
            steq_pkg::S_WALK:
            begin
                if (stat.walk_cont)
                begin
                    cmd.walk_step = 1'b1;
                    cmd.rd_sel    = steq_pkg::RD_LINK;
                end
                else if (stat.func == steq_pkg::FUNC_POST)
                begin
                    cmd.link_op = steq_pkg::LW_POST_PREV;
                    state_next  = steq_pkg::S_FIN;
                end
                else if (stat.found)
                begin
                    cmd.link_op = steq_pkg::LW_DEL_PREV;
                    state_next  = steq_pkg::S_FIN;
                end
                else
                begin
                    cmd.emit   = steq_pkg::EM_NOT_FOUND;
                    state_next = steq_pkg::S_IDLE;
                end
            end
            steq_pkg::S_FIN:
            begin
                if (stat.func == steq_pkg::FUNC_POST)
                begin
                    cmd.link_op = steq_pkg::LW_POST_SELF;
                    cmd.emit    = steq_pkg::EM_POSTED;
                end
                else
                begin
                    cmd.link_op = steq_pkg::LW_DEL_FREE;
                    cmd.emit    = steq_pkg::EM_DELETED;
                end
                state_next = steq_pkg::S_IDLE;
            end
            steq_pkg::S_TICK:
            begin
                if (stat.expire)
                begin
                    cmd.link_op = steq_pkg::LW_TICK;
                    cmd.rd_sel  = steq_pkg::RD_LINK;
                    if (stat.any_expired)
                    begin
                        cmd.emit = steq_pkg::EM_HOLD;
                    end
                end
                else
                begin
                    if (stat.any_expired)
                    begin
                        cmd.emit = steq_pkg::EM_HOLD_LAST;
                    end
                    else
                    begin
                        cmd.emit = steq_pkg::EM_NO_EXPIRY;
                    end
                    state_next = steq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = steq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/steq_dp.sv
// datapath of the sorted timer event queue: pool memories, list heads, time and results
module steq_dp #(
    parameter int POOL_SIZE = steq_pkg::POOL_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  steq_pkg::req_t  req,
    input  logic            cfg_valid,
    input  logic [31:0]     cfg_data,
    input  steq_pkg::cmd_t  cmd,
    output steq_pkg::stat_t stat,
    output logic            rsp_valid,
    output steq_pkg::rsp_t  rsp
);

    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

    // pool memories
    logic [63:0]       entry_time_reg    [POOL_SIZE];
    logic [15:0]       entry_handler_reg [POOL_SIZE];
    logic [31:0]       entry_param_reg   [POOL_SIZE];
    logic [LINK_W-1:0] link_next_reg     [POOL_SIZE];
    logic [POOL_SIZE-1:0] link_vld_reg;

    // registered read port
    logic [63:0]       rd_time_reg;
    logic [15:0]       rd_handler_reg;
    logic [31:0]       rd_param_reg;
    logic [LINK_W-1:0] rd_link_reg;
    logic              rd_vld_reg;
    logic [LINK_W-1:0] rd_addr_reg;
    logic [LINK_W-1:0] rd_addr;
    logic [LINK_W-1:0] link_rd;

    // list and time state
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] free_reg, free_next;
    logic [63:0]       now_reg;
    logic [31:0]       tick_ns_reg;
    logic [steq_pkg::CNT_W-1:0] n_reg;

    // walk and item state
    steq_pkg::req_t    req_reg;
    logic [LINK_W-1:0] cur_reg;
    logic [LINK_W-1:0] prev_reg;
    logic [LINK_W-1:0] e_reg;
    logic [LINK_W-1:0] steps_reg;
    logic [LINK_W-1:0] hold_idx_reg;
    logic [15:0]       hold_handler_reg;
    logic [31:0]       hold_param_reg;

    // result beat
    steq_pkg::rsp_t    rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // link write port
    logic              lw_en;
    logic [LINK_W-1:0] lw_addr;
    logic [LINK_W-1:0] lw_data;

    logic cur_ent;
    logic prev_ent;
    logic head_ent;

    assign cur_ent  = (cur_reg < NIL);
    assign prev_ent = (prev_reg < NIL);
    assign head_ent = (head_reg < NIL);

    // an entry never written into the link table still holds its reset chain
    assign link_rd = rd_vld_reg ? rd_link_reg : rd_addr_reg + LINK_W'(1);

    // read address select
    always_comb
    begin
        case (cmd.rd_sel)
            steq_pkg::RD_FREE: rd_addr = free_reg;
            steq_pkg::RD_LINK: rd_addr = link_rd;
            default:           rd_addr = head_reg;
        endcase
    end

    // link updates and list head moves
    always_comb
    begin
        lw_en     = 1'b0;
        lw_addr   = cur_reg;
        lw_data   = free_reg;
        head_next = head_reg;
        free_next = free_reg;
        if (cmd.pop_free)
        begin
            free_next = link_rd;
        end
        unique case (cmd.link_op)
            steq_pkg::LW_POST_PREV:
            begin
                if (prev_ent)
                begin
                    lw_en   = 1'b1;
                    lw_addr = prev_reg;
                    lw_data = e_reg;
                end
                else
                begin
                    head_next = e_reg;
                end
            end
            steq_pkg::LW_POST_SELF:
            begin
                lw_en   = 1'b1;
                lw_addr = e_reg;
                lw_data = cur_reg;
            end
            steq_pkg::LW_DEL_PREV:
            begin
                if (prev_ent)
                begin
                    lw_en   = 1'b1;
                    lw_addr = prev_reg;
                    lw_data = link_rd;
                end
                else
                begin
                    head_next = link_rd;
                end
            end
            steq_pkg::LW_DEL_FREE:
            begin
                lw_en     = 1'b1;
                lw_addr   = cur_reg;
                lw_data   = free_reg;
                free_next = cur_reg;
            end
            steq_pkg::LW_TICK:
            begin
                lw_en     = 1'b1;
                lw_addr   = head_reg;
                lw_data   = free_reg;
                head_next = link_rd;
                free_next = head_reg;
            end
            default:
            begin
                lw_en = 1'b0;
            end
        endcase
    end

    // memories: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        rd_time_reg    <= entry_time_reg[rd_addr[IDX_W-1:0]];
        rd_handler_reg <= entry_handler_reg[rd_addr[IDX_W-1:0]];
        rd_param_reg   <= entry_param_reg[rd_addr[IDX_W-1:0]];
        rd_link_reg    <= link_next_reg[rd_addr[IDX_W-1:0]];
        rd_vld_reg     <= link_vld_reg[rd_addr[IDX_W-1:0]];
        rd_addr_reg    <= rd_addr;
        if (cmd.pop_free)
        begin
            entry_time_reg[free_reg[IDX_W-1:0]]    <= req_reg.event_time;
            entry_handler_reg[free_reg[IDX_W-1:0]] <= req_reg.handler_id;
            entry_param_reg[free_reg[IDX_W-1:0]]   <= req_reg.param;
        end
        if (lw_en)
        begin
            link_next_reg[lw_addr[IDX_W-1:0]] <= lw_data;
        end
    end

    // link valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (lw_en)
        begin
            link_vld_reg[lw_addr[IDX_W-1:0]] <= 1'b1;
        end
    end

    // result beat select
    always_comb
    begin
        rsp_next       = '0;
        rsp_next.last  = 1'b1;
        rsp_valid_next = 1'b1;
        case (cmd.emit) inside
            steq_pkg::EM_FULL:
            begin
                rsp_next.status = steq_pkg::ST_FULL;
            end
            steq_pkg::EM_POSTED:
            begin
                rsp_next.status       = steq_pkg::ST_POSTED;
                rsp_next.result_index = 6'(e_reg);
            end
            steq_pkg::EM_DELETED:
            begin
                rsp_next.status       = steq_pkg::ST_DELETED;
                rsp_next.result_index = 6'(cur_reg);
            end
            steq_pkg::EM_NOT_FOUND:
            begin
                rsp_next.status = steq_pkg::ST_NOT_FOUND;
            end
            steq_pkg::EM_NO_EXPIRY:
            begin
                rsp_next.status = steq_pkg::ST_NONE;
            end
            steq_pkg::EM_HOLD,
            steq_pkg::EM_HOLD_LAST:
            begin
                rsp_next.status          = steq_pkg::ST_EXPIRED;
                rsp_next.result_index    = 6'(hold_idx_reg);
                rsp_next.expired_handler = hold_handler_reg;
                rsp_next.expired_param   = hold_param_reg;
                rsp_next.last            = (cmd.emit == steq_pkg::EM_HOLD_LAST);
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            free_reg      <= '0;
            now_reg       <= '0;
            tick_ns_reg   <= steq_pkg::TICK_NS_RESET;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                tick_ns_reg <= cfg_data;
            end
            if (cmd.now_adv)
            begin
                now_reg <= now_reg + 64'(tick_ns_reg);
            end
            if (cmd.tick_init)
            begin
                n_reg <= '0;
            end
            else if (cmd.link_op == steq_pkg::LW_TICK)
            begin
                n_reg <= n_reg + steq_pkg::CNT_W'(1);
            end
        end
    end

    // item, walk and result payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.load_item)
        begin
            req_reg <= req;
        end
        if (cmd.pop_free)
        begin
            e_reg <= free_reg;
        end
        if (cmd.walk_init)
        begin
            cur_reg   <= head_next;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            cur_reg   <= link_rd;
            prev_reg  <= cur_reg;
            steps_reg <= steps_reg + LINK_W'(1);
        end
        if (cmd.link_op == steq_pkg::LW_TICK)
        begin
            hold_idx_reg     <= head_reg;
            hold_handler_reg <= rd_handler_reg;
            hold_param_reg   <= rd_param_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.func        = req_reg.func;
        stat.free_empty  = (free_reg >= NIL);
        stat.found       = cur_ent && (8'(cur_reg) == 8'(req_reg.entry_index));
        stat.walk_cont   = cur_ent && (steps_reg < NIL) &&
                           ((req_reg.func == steq_pkg::FUNC_POST) ?
                            (req_reg.event_time > rd_time_reg) :
                            (8'(cur_reg) != 8'(req_reg.entry_index)));
        stat.expire      = (n_reg < steq_pkg::CNT_W'(steq_pkg::MAX_RESULTS)) &&
                           head_ent && (rd_time_reg <= now_reg);
        stat.any_expired = (n_reg != '0);
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

### hw/rtl/sorted_timer_event_queue_top.sv
// top level of the sorted timer event queue
//
//   channel   handshake                 payload
//   input     start, busy               req  (func, event_time, handler_id, param, entry_index)
//   result    rsp_valid (strobe)        rsp  (status, result_index, expired_handler,
//                                             expired_param, last)
//   config    cfg_valid, cfg_ready      cfg_data (tick_ns)
//
// post and delete step over k pending entries; the pending list walk reads one
// entry a cycle through the registered pool memory port, so k reaches POOL_SIZE
// at most. tick: at most 32 expiries per tick.
// results leave one per cycle on rsp_valid; the receiver cannot stall them.
// reset takes effect at once: link table chain comes from per-entry valid bits.
module sorted_timer_event_queue_top #(
    parameter int POOL_SIZE = steq_pkg::POOL_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  steq_pkg::req_t req,
    output logic           rsp_valid,
    output steq_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [31:0]    cfg_data
);

    steq_pkg::cmd_t  cmd;
    steq_pkg::stat_t stat;

    // configuration beat taken whenever offered
    assign cfg_ready = 1'b1;

    // controller
    steq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    steq_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
